// ----- design/heat_diffusion_stencil_1d_defines.svh -----
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_1d_defines.svh
// Assertion macros shared by the heat diffusion stencil modules.
// ----------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_1D_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_1D_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define HDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define HDS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define HDS_ASSERT(lbl, prop, msg)
`define HDS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- design/hds_pkg.sv -----
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types and constants of the 1D heat diffusion stencil.
// ----------------------------------------------------------------------------
package hds_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int GRID_LEN_W  = 11;
    localparam int RATIO_W     = 16;
    localparam int STEP_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATIO       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_COUNT  = 2'd2;

    localparam logic [GRID_LEN_W-1:0] RST_GRID_LENGTH = 11'd1024;
    localparam logic [RATIO_W-1:0]    RST_RATIO       = 16'd655;
    localparam logic [STEP_W-1:0]     RST_STEP_COUNT  = 16'd50;

    // Result queue depth, a power of two.
    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic                  item_accept;
        logic                  item_reply;
        logic                  run_start;
        logic                  issue;
        logic                  step_done;
        logic                  run_done;
        logic [RATIO_W-1:0]    ratio;
        logic [GRID_LEN_W-1:0] grid_length;
    } t_dp_cmd;

    typedef struct packed {
        logic q_room;
        logic sweep_last;
        logic pipe_empty;
    } t_dp_status;

endpackage

// ----- design/hds_ram.sv -----
// ----------------------------------------------------------------------------
// hds_ram
// One grid bank: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hds_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 18
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/hds_outq.sv -----
// ----------------------------------------------------------------------------
// hds_outq
// Small result queue between the datapath and the output channel.
// ----------------------------------------------------------------------------
module hds_outq
    import hds_pkg::*;
#(
    parameter int WIDTH = 21
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [WIDTH-1:0]                  i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [WIDTH-1:0]                  o_data,
    output logic [$clog2(OUTQ_DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            priority if (i_push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/hds_datapath.sv -----
// ----------------------------------------------------------------------------
// hds_datapath
// Grid banks, stencil pipeline, saturation flag and result queue.
// ----------------------------------------------------------------------------
`include "heat_diffusion_stencil_1d_defines.svh"

module hds_datapath
    import hds_pkg::*;
#(
    parameter int GRID_DEPTH   = 1024,
    parameter int SAMPLE_WIDTH = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_status                     o_status,
    input  logic [1:0]                     i_action,
    input  logic [9:0]                     i_index,
    input  logic signed [SAMPLE_WIDTH-1:0] i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_read_value,
    output logic [1:0]                     o_ack_kind,
    output logic                           o_saturated
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int AW    = $clog2(GRID_DEPTH);
    localparam int LW    = AW + 1;
    localparam int DW    = SW + 2;
    localparam int PW    = DW + 17;
    localparam int RW    = PW + 1;
    localparam int NW    = RW - 16 + 1;
    localparam int QW    = SW + 3;
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic signed [RW-1:0] RoundHalf = RW'(32768);
    localparam logic signed [NW-1:0] SatMax    = NW'((longint'(1) <<< (SW - 1)) - 1);
    localparam logic signed [NW-1:0] SatMin    = NW'(-(longint'(1) <<< (SW - 1)));

    typedef enum logic [1:0] {
        PK_COPY,
        PK_ZERO,
        PK_UPDATE
    } t_point_kind;

    // Bank control and sweep address
    logic                 r_active;
    logic [LW-1:0]        r_k;
    logic [LW-1:0]        k_m1;
    logic                 sweep_last;
    logic [AW-1:0]        sweep_addr;
    logic                 in_range;
    logic [AW-1:0]        item_addr;
    logic                 item_wr;
    logic                 item_rd;
    logic [LW-1:0]        len;
    logic [LW-1:0]        len_last;

    logic                 we_a, we_b, re_a, re_b;
    logic [AW-1:0]        waddr_a, waddr_b, raddr;
    logic [SW-1:0]        wdata_a, wdata_b;
    logic [SW-1:0]        rdata_a, rdata_b;
    logic signed [SW-1:0] rdata;

    // Stencil pipeline
    logic                 r_v1;
    logic [AW-1:0]        r_pt1;
    logic signed [SW-1:0] r_cur;
    logic signed [SW-1:0] r_prev;
    logic signed [DW-1:0] d;
    logic signed [PW-1:0] prod;
    t_point_kind          kind1;

    logic                 r_v2;
    logic [AW-1:0]        r_pt2;
    logic signed [SW-1:0] r_u2;
    logic signed [PW-1:0] r_prod;
    t_point_kind          r_kind2;

    logic signed [RW-1:0]    rsum;
    logic signed [RW-17:0]   delta;
    logic signed [NW-1:0]    nv;
    logic                    sat_hi, sat_lo;
    logic signed [SW-1:0]    upd_val;
    logic signed [SW-1:0]    wb_value;

    // Results
    logic                 r_sat;
    logic                 r_pend_v;
    logic [1:0]           r_pend_kind;
    logic                 r_pend_rd;
    logic [QW-1:0]        push_data;
    logic [QW-1:0]        q_data;
    logic [CNT_W-1:0]     q_count;

    // ---------------- addressing ----------------
    assign sweep_last = (r_k == LW'(GRID_DEPTH));
    assign sweep_addr = sweep_last ? '0 : r_k[AW-1:0];
    assign k_m1       = r_k - LW'(1);
    assign in_range   = (32'(i_index) < 32'(GRID_DEPTH));
    assign item_addr  = AW'(i_index);
    assign item_wr    = i_cmd.item_accept && (i_action == ACT_WRITE) && in_range;
    assign item_rd    = i_cmd.item_accept && (i_action == ACT_READ) && in_range;
    assign len        = (32'(i_cmd.grid_length) >= 32'(GRID_DEPTH)) ? LW'(GRID_DEPTH)
                                                                    : LW'(i_cmd.grid_length);
    assign len_last   = len - LW'(1);

    // Item writes go to the active bank, sweep writebacks to the other one.
    assign we_a    = r_active ? r_v2 : item_wr;
    assign we_b    = r_active ? item_wr : r_v2;
    assign waddr_a = r_active ? r_pt2 : item_addr;
    assign waddr_b = r_active ? item_addr : r_pt2;
    assign wdata_a = r_active ? wb_value : i_value;
    assign wdata_b = r_active ? i_value : wb_value;
    assign re_a    = !r_active && (i_cmd.issue || item_rd);
    assign re_b    = r_active && (i_cmd.issue || item_rd);
    assign raddr   = i_cmd.issue ? sweep_addr : item_addr;
    assign rdata   = $signed(r_active ? rdata_b : rdata_a);

    hds_ram #(
        .DEPTH (GRID_DEPTH),
        .WIDTH (SW)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata_a),
        .i_re    (re_a),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    hds_ram #(
        .DEPTH (GRID_DEPTH),
        .WIDTH (SW)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (wdata_b),
        .i_re    (re_b),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
        end else begin
            if (i_cmd.step_done) begin
                r_active <= !r_active;
            end
            if (i_cmd.issue) begin
                r_k <= sweep_last ? '0 : r_k + LW'(1);
            end
        end
    end

    // ---------------- stage 1: window and product ----------------
    // rdata holds src[k], r_cur src[k-1], r_prev src[k-2] for point k-1.
    assign d    = DW'(rdata) - (DW'(r_cur) <<< 1) + DW'(r_prev);
    assign prod = PW'($signed({1'b0, i_cmd.ratio})) * PW'(d);

    always_comb begin
        priority if (LW'(r_pt1) >= len) begin
            kind1 = PK_COPY;
        end else if ((r_pt1 == '0) || (LW'(r_pt1) == len_last)) begin
            kind1 = PK_ZERO;
        end else begin
            kind1 = PK_UPDATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prev <= r_cur;
            r_cur  <= rdata;
            r_pt1  <= k_m1[AW-1:0];
        end
        r_pt2   <= r_pt1;
        r_u2    <= r_cur;
        r_prod  <= prod;
        r_kind2 <= kind1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue && (r_k != '0);
            r_v2 <= r_v1;
        end
    end

    // ---------------- stage 2: round, add, saturate ----------------
    assign rsum    = RW'(r_prod) + RoundHalf;
    assign delta   = $signed(rsum[RW-1:16]);
    assign nv      = NW'(r_u2) + NW'(delta);
    assign sat_hi  = (nv > SatMax);
    assign sat_lo  = (nv < SatMin);
    assign upd_val = sat_hi ? SatMax[SW-1:0] : (sat_lo ? SatMin[SW-1:0] : nv[SW-1:0]);

    always_comb begin
        unique case (r_kind2)
            PK_COPY:   wb_value = r_u2;
            PK_ZERO:   wb_value = '0;
            PK_UPDATE: wb_value = upd_val;
            default:   wb_value = r_u2;
        endcase
    end

    // ---------------- results ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            priority if (i_cmd.run_start) begin
                r_sat <= 1'b0;
            end else if (r_v2 && (r_kind2 == PK_UPDATE) && (sat_hi || sat_lo)) begin
                r_sat <= 1'b1;
            end
            r_pend_v <= i_cmd.item_reply || i_cmd.run_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_kind <= i_cmd.run_done ? ACT_RUN : i_action;
        r_pend_rd   <= !i_cmd.run_done && item_rd;
    end

    assign push_data = {(r_pend_rd ? rdata : '0), r_pend_kind, r_sat};

    hds_outq #(
        .WIDTH (QW)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pend_v),
        .i_data  (push_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_read_value = $signed(q_data[QW-1:3]);
    assign o_ack_kind   = q_data[2:1];
    assign o_saturated  = q_data[0];

    assign o_status.q_room     = ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(r_pend_v))
                                 < (CNT_W + 1)'(OUTQ_DEPTH);
    assign o_status.sweep_last = sweep_last;
    assign o_status.pipe_empty = !r_v1 && !r_v2;

    `HDS_ASSERT_NEVER(a_bank_write_clash, item_wr && r_v2, "item write during sweep writeback")
    `HDS_ASSERT(a_queue_no_overflow, r_pend_v |-> (q_count < CNT_W'(OUTQ_DEPTH)), "result queue overflow")
    `HDS_ASSERT(a_no_reply_in_sweep, i_cmd.issue |-> !r_pend_v, "result pending during sweep")

endmodule

// ----- design/hds_ctrl.sv -----
// ----------------------------------------------------------------------------
// hds_ctrl
// Configuration registers and the sequencer for run actions.
// ----------------------------------------------------------------------------
`include "heat_diffusion_stencil_1d_defines.svh"

module hds_ctrl
    import hds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_action,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_dp_cmd                o_cmd,
    input  t_dp_status             i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } t_state;

    t_state                r_state;
    logic [STEP_W-1:0]     r_step;
    logic [GRID_LEN_W-1:0] r_len;
    logic [RATIO_W-1:0]    r_ratio;
    logic [STEP_W-1:0]     r_steps;
    logic                  accept;
    logic                  is_run;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= RST_GRID_LENGTH;
            r_ratio <= RST_RATIO;
            r_steps <= RST_STEP_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_LENGTH: r_len   <= i_cfg_data[GRID_LEN_W-1:0];
                CFG_RATIO:       r_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_STEP_COUNT:  r_steps <= i_cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE) || !i_status.q_room;
        accept  = i_valid && !o_stall;
        is_run  = (i_action == ACT_RUN);

        o_cmd.item_accept = accept;
        o_cmd.run_start   = accept && is_run;
        // A run with no steps answers at once, like any other action.
        o_cmd.item_reply  = accept && !(is_run && (r_steps != '0));
        o_cmd.issue       = (r_state == ST_SWEEP);
        o_cmd.step_done   = (r_state == ST_DRAIN) && i_status.pipe_empty;
        o_cmd.run_done    = o_cmd.step_done && (r_step == r_steps);
        o_cmd.ratio       = r_ratio;
        o_cmd.grid_length = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.run_start && (r_steps != '0)) begin
                        r_state <= ST_SWEEP;
                        r_step  <= STEP_W'(1);
                    end
                end
                ST_SWEEP: begin
                    if (i_status.sweep_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (i_status.pipe_empty) begin
                        if (r_step == r_steps) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_step  <= r_step + STEP_W'(1);
                            r_state <= ST_SWEEP;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `HDS_ASSERT(a_run_enters_sweep, (o_cmd.run_start && (r_steps != '0)) |=> (r_state == ST_SWEEP && r_step == 16'd1), "run did not start sweeping")
    `HDS_ASSERT(a_step_in_bounds, (r_state == ST_SWEEP) |-> (r_step != '0 && r_step <= r_steps), "step counter out of bounds")
    `HDS_ASSERT(a_drain_after_last, (r_state == ST_DRAIN && $past(r_state) == ST_SWEEP) |-> $past(i_status.sweep_last), "drain entered before sweep end")

endmodule

// ----- design/heat_diffusion_stencil_1d.sv -----
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_1d
// Explicit 1D heat equation solver over a two-bank grid of Q1.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one item: action, index, value.
//   Write and read actions, and the unused action code, are taken one per
//   cycle while o_stall is low; each result goes through a pending register
//   into the result queue. A run action sweeps the whole store once per time
//   step, through the single read port of the source bank and the stencil
//   pipeline, which drains before the banks swap. Its result item is queued
//   once the last step is done; o_stall stays high for the whole run.
//   Output channel (o_valid / i_stall) is fed from a four-entry result queue;
//   while the receiver stalls, items pile up there and o_stall rises once the
//   queue plus the item in flight would fill it.
//   Configuration port (i_cfg_valid / o_cfg_ready) is always ready; write it
//   only while the block is idle. Index 0 grid length, 1 ratio, 2 step count.
//   Reset clears the queue, the saturation flag and the bank select and loads
//   the register defaults; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_1d
    import hds_pkg::*;
#(
    parameter int GRID_DEPTH   = 1024,
    parameter int SAMPLE_WIDTH = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_action,
    input  logic [9:0]                     i_index,
    input  logic signed [SAMPLE_WIDTH-1:0] i_value,
    // result items
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_read_value,
    output logic [1:0]                     o_ack_kind,
    output logic                           o_saturated,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    // Commands flow from the sequencer to the datapath, status flows back.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    hds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // Banks, stencil pipeline and result queue.
    hds_datapath #(
        .GRID_DEPTH   (GRID_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_ack_kind   (o_ack_kind),
        .o_saturated  (o_saturated)
    );

endmodule

// ----- tb/tb_heat_diffusion_stencil_1d.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heat_diffusion_stencil_1d
// Self-checking bench for the 1D heat diffusion stencil. A shadow grid of two
// banks computes the expected ack for every write, run, read and unused
// action, and a monitor compares each ack field by field. Grid settings
// change between phases once the block has drained; both sides insert
// random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_heat_diffusion_stencil_1d;
    import hds_pkg::*;

    localparam int     GRID_DEPTH     = 1024;
    localparam int     SAMPLE_W       = 18;
    localparam longint SAMPLE_MAX     = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
    localparam int     DIRECTED_ITEMS = 25;
    localparam int     RANDOM_ITEMS   = 1050;
    // Runs longer than this are never issued: each step sweeps the whole store.
    localparam int     MAX_RUN_STEPS  = 32;
    localparam int     WATCHDOG_LIMIT = 4 * (MAX_RUN_STEPS * (GRID_DEPTH + 4) + 200);

    // Register index that maps to no register; writes there must do nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        t_action     action;
        logic [9:0]  index;
        sample_t     value;
    } grid_action_t;

    typedef struct packed {
        sample_t     read_value;
        logic [1:0]  ack_kind;
        logic        saturated;
    } grid_ack_t;

    typedef struct packed {
        grid_action_t act;
        grid_ack_t    ack;
    } queued_action_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    logic [1:0]             i_action    = '0;
    logic [9:0]             i_index     = '0;
    sample_t                i_value     = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    sample_t                o_read_value;
    logic [1:0]             o_ack_kind;
    logic                   o_saturated;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    always #5 i_clk = ~i_clk;

    heat_diffusion_stencil_1d #(
        .GRID_DEPTH   (GRID_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_ack_kind   (o_ack_kind),
        .o_saturated  (o_saturated),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow grid: two banks, the bank select, the sticky flag and the
    // registers. The written flags track which entries hold defined data, so
    // the stimulus never reads or diffuses an entry that was never loaded.
    // ------------------------------------------------------------------------
    sample_t                grid_shadow [2][GRID_DEPTH];
    bit                     written     [2][GRID_DEPTH];
    bit                     live_bank = 1'b0;
    bit                     sat_flag  = 1'b0;
    logic [GRID_LEN_W-1:0]  len_reg   = RST_GRID_LENGTH;
    logic [RATIO_W-1:0]     ratio_reg = RST_RATIO;
    logic [STEP_W-1:0]      steps_reg = RST_STEP_COUNT;

    queued_action_t queued_actions[$];   // built by the stimulus, drained by the driver
    grid_ack_t      expected_acks[$];    // acks of accepted items, oldest first

    int item_count     = 0;
    int run_count      = 0;
    int step_total     = 0;
    int sat_runs       = 0;
    int setting_count  = 0;
    int mismatch_count = 0;

    // Points in use: the register clamped to the store depth.
    function automatic int grid_in_use();
        return (len_reg < GRID_DEPTH) ? int'(len_reg) : GRID_DEPTH;
    endfunction

    // One explicit time step from the live bank into the other one.
    function automatic void diffuse_one_step();
        int     len;
        int     i;
        bit     src;
        bit     dst;
        longint u;
        longint lap;
        longint r_l;
        longint nv;
        src = live_bank;
        dst = !live_bank;
        len = grid_in_use();
        r_l = ratio_reg;
        for (i = 0; i < GRID_DEPTH; i++) begin
            if (i >= len) begin
                // carry points beyond the grid unchanged
                grid_shadow[dst][i] = grid_shadow[src][i];
                written[dst][i]     = written[src][i];
            end else if (i == 0 || i == len - 1) begin
                grid_shadow[dst][i] = '0;
                written[dst][i]     = 1'b1;
            end else begin
                u   = grid_shadow[src][i];
                lap = longint'(grid_shadow[src][i+1]) - 2 * u
                    + longint'(grid_shadow[src][i-1]);
                // round half up: add half an LSB, then floor the shift
                nv  = u + ((r_l * lap + 32768) >>> 16);
                if (nv > SAMPLE_MAX) begin
                    nv       = SAMPLE_MAX;
                    sat_flag = 1'b1;
                end else if (nv < SAMPLE_MIN) begin
                    nv       = SAMPLE_MIN;
                    sat_flag = 1'b1;
                end
                grid_shadow[dst][i] = sample_t'(nv);
                written[dst][i]     = 1'b1;
            end
        end
        live_bank = dst;
    endfunction

    // Apply one action to the shadow grid and return the ack it must produce.
    function automatic grid_ack_t apply_action(grid_action_t a);
        grid_ack_t ack;
        int        s;
        ack.read_value = '0;
        ack.ack_kind   = a.action;
        case (a.action)
            ACT_WRITE: begin
                grid_shadow[live_bank][a.index] = a.value;
                written[live_bank][a.index]     = 1'b1;
            end
            ACT_RUN: begin
                sat_flag = 1'b0;
                for (s = 0; s < steps_reg; s++) diffuse_one_step();
            end
            ACT_READ: ack.read_value = grid_shadow[live_bank][a.index];
            default: ;
        endcase
        ack.saturated = sat_flag;
        return ack;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic sample_t rand_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return sample_t'(SAMPLE_MAX);
            1:       return sample_t'(SAMPLE_MIN);
            2:       return sample_t'($urandom_range(0, 2) - 1);
            3, 4, 5: return sample_t'($urandom_range(0, 8191) - 4096);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Mostly inside the grid and just past its end, sometimes anywhere.
    function automatic int pick_index();
        int hi;
        hi = grid_in_use() + 7;
        if (hi > GRID_DEPTH - 1) hi = GRID_DEPTH - 1;
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, GRID_DEPTH - 1);
        return $urandom_range(0, hi);
    endfunction

    // Predict the ack now and queue the item for the driver.
    function automatic void issue(t_action kind, int idx, sample_t val);
        queued_action_t q;
        q.act.action = kind;
        q.act.index  = 10'(idx);
        q.act.value  = val;
        q.ack        = apply_action(q.act);
        queued_actions.push_back(q);
        item_count++;
        if (kind == ACT_RUN) begin
            run_count++;
            step_total += steps_reg;
            if (q.ack.saturated) sat_runs++;
        end
    endfunction

    // Never read an unloaded entry: load it instead.
    function automatic void send_read(int idx);
        if (written[live_bank][idx]) issue(ACT_READ, idx, rand_sample());
        else issue(ACT_WRITE, idx, rand_sample());
    endfunction

    // Skip runs over MAX_RUN_STEPS; else load every unloaded operand below the grid length, then run.
    function automatic void send_run();
        int len;
        int i;
        if (steps_reg > MAX_RUN_STEPS) return;
        len = grid_in_use();
        if (steps_reg != 0 && len >= 3) begin
            for (i = 0; i < len; i++) begin
                if (!written[live_bank][i]) issue(ACT_WRITE, i, rand_sample());
            end
        end
        issue(ACT_RUN, $urandom_range(0, GRID_DEPTH - 1), rand_sample());
    endfunction

    // One register write; returns at the edge where it was taken.
    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GRID_LENGTH: len_reg   = data[GRID_LEN_W-1:0];
            CFG_RATIO:       ratio_reg = data[RATIO_W-1:0];
            CFG_STEP_COUNT:  steps_reg = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Drain the block, let it settle, then load a new setting.
    task automatic apply_settings(logic [15:0] len_word, logic [15:0] ratio,
                                  logic [15:0] steps);
        while (queued_actions.size() != 0 || expected_acks.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        @(posedge i_clk);
        cfg_write(CFG_GRID_LENGTH, len_word);
        cfg_write(CFG_RATIO, ratio);
        cfg_write(CFG_STEP_COUNT, steps);
        cfg_write(CFG_UNUSED, 16'($urandom));
        i_cfg_valid <= 1'b0;
        setting_count++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the oldest queued item, hold it while stalled, and open
    // a random gap after each accepted item. Calm stretches drop all gaps.
    // ------------------------------------------------------------------------
    int send_gap       = 0;
    int send_calm_left = 0;
    bit send_calm      = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (send_calm_left == 0) begin
                send_calm      = ($urandom_range(0, 3) == 0);
                send_calm_left = $urandom_range(100, 400);
            end else begin
                send_calm_left--;
            end
            if (i_valid && !o_stall) begin
                // the item is taken: its ack is now due
                expected_acks.push_back(queued_actions[0].ack);
                void'(queued_actions.pop_front());
                send_gap = send_calm ? 0 : pick_gap();
            end
            if (i_valid && o_stall) begin
                // hold valid and payload
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (queued_actions.size() != 0) begin
                i_valid  <= 1'b1;
                i_action <= queued_actions[0].act.action;
                i_index  <= queued_actions[0].act.index;
                i_value  <= queued_actions[0].act.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted ack against the oldest expectation, and
    // stall the result channel at random.
    // ------------------------------------------------------------------------
    int recv_hold      = 0;
    int recv_calm_left = 0;
    bit recv_calm      = 1'b0;

    function automatic void compare_field(string field_name, sample_t want, sample_t got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_acks.size() == 0) begin
                    $display("%0t: ack with none expected, actual %0d/%0d/%0d",
                             $time, o_read_value, o_ack_kind, o_saturated);
                    mismatch_count++;
                end else begin
                    compare_field("read_value", expected_acks[0].read_value, o_read_value);
                    compare_field("ack_kind", sample_t'(expected_acks[0].ack_kind),
                                  sample_t'(o_ack_kind));
                    compare_field("saturated", sample_t'(expected_acks[0].saturated),
                                  sample_t'(o_saturated));
                    void'(expected_acks.pop_front());
                end
            end
            if (recv_calm_left == 0) begin
                recv_calm      = ($urandom_range(0, 3) == 0);
                recv_calm_left = $urandom_range(100, 400);
            end else begin
                recv_calm_left--;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_stall <= 1'b1;
            end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
                recv_hold = pick_gap();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no channel moves for too long.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        int          phase;
        int          r;
        int          n;
        int          len;
        int          random_start;
        bit          full_done;
        logic [15:0] len_word;
        logic [15:0] ratio;
        logic [15:0] steps;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes on a five-point grid with the largest ratio: the
        // alternating max/min profile must saturate on the first step.
        apply_settings(16'd5, 16'hFFFF, 16'd1);
        issue(ACT_WRITE, 0, sample_t'(SAMPLE_MAX));
        issue(ACT_WRITE, 1, sample_t'(SAMPLE_MIN));
        issue(ACT_WRITE, 2, sample_t'(SAMPLE_MAX));
        issue(ACT_WRITE, 3, sample_t'(SAMPLE_MIN));
        issue(ACT_WRITE, 4, '0);
        issue(ACT_WRITE, 5, sample_t'(18'h15555));
        issue(ACT_WRITE, GRID_DEPTH - 1, sample_t'(18'h2AAAA));
        send_read(0);
        send_read(1);
        send_read(GRID_DEPTH - 1);
        issue(ACT_NONE, GRID_DEPTH - 1, sample_t'(-1));
        send_run();
        send_read(2);
        send_read(5);      // beyond the grid: carried unchanged
        send_read(4);      // end point forced to zero
        issue(ACT_WRITE, 2, '0);   // flag stays set across a write

        // Zero step count on an over-long grid: the flag clears, nothing moves.
        apply_settings(16'h07FF, 16'd0, 16'd0);
        send_run();
        send_read(1);

        // Two-point grid: both points in use become zero.
        apply_settings(16'd2, 16'd32768, 16'd1);
        send_run();
        send_read(1);
        send_read(3);

        // Empty grid (upper data bits are dropped): every point carried.
        apply_settings(16'hF800, 16'd655, 16'd1);
        send_run();
        send_read(4);

        // One-point grid.
        apply_settings(16'd1, 16'd1, 16'd1);
        send_run();
        send_read(0);
        send_read(GRID_DEPTH - 1);

        // Random phases: small grids first; full-length grids only in the
        // second half, where loading the whole store pays off.
        random_start = item_count;
        full_done    = 1'b0;
        phase        = 0;
        while (item_count - random_start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (phase == 0) begin
                len = 3;
            end else if (item_count - random_start < RANDOM_ITEMS / 2) begin
                len = (r < 8) ? $urandom_range(0, 2) : (r < 25) ? 3 : $urandom_range(4, 40);
            end else if (!full_done) begin
                len       = GRID_DEPTH;
                full_done = 1'b1;
            end else begin
                len = (r < 30) ? $urandom_range(4, 40) :
                      (r < 45) ? $urandom_range(0, 3)  :
                      (r < 70) ? $urandom_range(41, GRID_DEPTH - 1) :
                      (r < 85) ? GRID_DEPTH : $urandom_range(GRID_DEPTH + 1, 2047);
            end
            len_word = 16'(len);
            if ($urandom_range(0, 4) == 0) len_word[15:GRID_LEN_W] = 5'($urandom);

            r = $urandom_range(0, 99);
            ratio = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : (r < 35) ? 16'd32768 :
                    (r < 80) ? 16'($urandom_range(0, 32768)) : 16'($urandom);

            r = $urandom_range(0, 99);
            steps = (r < 10) ? 16'd0 : (r < 60) ? 16'($urandom_range(1, 2)) :
                    (r < 90) ? 16'($urandom_range(3, 8)) :
                    (r < 98) ? 16'($urandom_range(9, MAX_RUN_STEPS)) : 16'hFFFF;
            // phase 2 always loads the longest step count; runs are skipped under it
            if (phase == 2) steps = 16'hFFFF;

            apply_settings(len_word, ratio, steps);

            n = $urandom_range(10, 60);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    issue(ACT_WRITE, pick_index(), rand_sample());
                end else if (r < 82) begin
                    send_read(pick_index());
                end else if (r < 88) begin
                    send_run();
                end else if (r < 93) begin
                    // run, then probe three points of the grid
                    send_run();
                    repeat (3) send_read(pick_index());
                end else begin
                    issue(ACT_NONE, $urandom_range(0, GRID_DEPTH - 1), rand_sample());
                end
            end
            phase++;
        end

        // Wait for every ack, then give stray acks time to show up.
        while (queued_actions.size() != 0 || expected_acks.size() != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        $display("Summary: %0d items over %0d settings, %0d runs, %0d time steps",
                 item_count, setting_count, run_count, step_total);
        $display("Summary: %0d runs saturated, %0d mismatches", sat_runs, mismatch_count);
        if (mismatch_count == 0 && expected_acks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
